// ===== design/go_back_n_sender_window_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the go-back-N sender window core
// Shared clock and reset wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_CORE_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_CORE_ASSERT_SVH

// Check on every rising edge of clk_i outside reset.
`define GBN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gbn assertion failed");

// Check on every rising edge of clk_i, reset included.
`define GBN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("gbn assertion failed");

`endif

// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, widths and codes shared by the go-back-N sender window core.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W      = 20;
  localparam int OFF_W      = 31;
  localparam int CNT_W      = 11;
  localparam int WIN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [WIN_W-1:0] MAX_WINDOW    = 7'd64;
  localparam logic [CNT_W-1:0] SEGMENT_BYTES = 11'd1494;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_BYTES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [SEQ_W-1:0] ack_number;
  } in_t;

  typedef struct packed {
    logic             send_valid;
    logic [SEQ_W-1:0] seq_number;
    logic [OFF_W-1:0] byte_offset;
    logic [CNT_W-1:0] byte_count;
    logic             transfer_done;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [SEQ_W-1:0] total_segments;
    logic [CNT_W-1:0] last_bytes;
    logic [WIN_W-1:0] window;
  } cfg_t;

endpackage

// ===== design/gbn_cfg.sv =====
// ----------------------------------------------------------------------------
// gbn_cfg
// Configuration registers with range clamping of window and last length.
// ----------------------------------------------------------------------------
module gbn_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output gbn_pkg::cfg_t                  cfg_o
);

  logic [gbn_pkg::SEQ_W-1:0] total_q;
  logic [gbn_pkg::CNT_W-1:0] last_bytes_q;
  logic [gbn_pkg::WIN_W-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= 20'd1;
      last_bytes_q <= gbn_pkg::SEGMENT_BYTES;
      window_q     <= gbn_pkg::MAX_WINDOW;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gbn_pkg::CFG_TOTAL_SEGMENTS: total_q      <= cfg_data_i[gbn_pkg::SEQ_W-1:0];
        gbn_pkg::CFG_LAST_BYTES:     last_bytes_q <= cfg_data_i[gbn_pkg::CNT_W-1:0];
        gbn_pkg::CFG_WINDOW_SIZE:    window_q     <= cfg_data_i[gbn_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.total_segments = total_q;
    cfg_o.last_bytes     = (last_bytes_q > gbn_pkg::SEGMENT_BYTES) ?
                           gbn_pkg::SEGMENT_BYTES : last_bytes_q;
    if (window_q == '0) begin
      cfg_o.window = 7'd1;
    end else if (window_q > gbn_pkg::MAX_WINDOW) begin
      cfg_o.window = gbn_pkg::MAX_WINDOW;
    end else begin
      cfg_o.window = window_q;
    end
  end

endmodule

// ===== design/gbn_mul.sv =====
// ----------------------------------------------------------------------------
// gbn_mul
// Shift-add multiplier by the segment size, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gbn_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gbn_pkg::SEQ_W-1:0] operand_i,
  output logic                      done_o,
  output logic [gbn_pkg::OFF_W-1:0] product_o
);

  localparam int BIT_W = $clog2(gbn_pkg::CNT_W);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(gbn_pkg::CNT_W - 1);

  logic                      run_q;
  logic                      done_q;
  logic [BIT_W-1:0]          bit_q;
  logic [gbn_pkg::OFF_W-1:0] mcand_q;
  logic [gbn_pkg::OFF_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        bit_q <= '0;
      end else if (run_q) begin
        if (bit_q == LAST_BIT) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          bit_q <= bit_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= {{(gbn_pkg::OFF_W - gbn_pkg::SEQ_W){1'b0}}, operand_i};
    end else if (run_q) begin
      if (gbn_pkg::SEGMENT_BYTES[bit_q]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q <= {mcand_q[gbn_pkg::OFF_W-2:0], 1'b0};
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== design/go_back_n_sender_window_core.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// Go-back-N sender window. An item (start, acknowledgement or timeout) is
// taken while in_stall_o is low; the core then stalls its input until every
// send command for that item has been delivered, one per cycle at most. An
// item that sends segments goes through the accept step, two planning
// steps, the shift-add multiplier that forms the first byte offset, a
// hand-off and one send command per cycle while the output is not stalled;
// later offsets advance by the segment size. An item with nothing to send
// yields one status result; the unknown code skips the window planning step.
// Configuration is to be written while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gbn_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gbn_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PLAN = 3'd1;
  localparam logic [2:0] ST_WIN  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  gbn_pkg::cfg_t cfg;

  logic [2:0]                  state_q, state_d;
  logic [1:0]                  func_q;
  logic [gbn_pkg::SEQ_W-1:0]   ack_q;
  logic [gbn_pkg::SEQ_W-1:0]   acked_base_q;
  logic [gbn_pkg::SEQ_W-1:0]   highest_sent_q;
  logic [gbn_pkg::SEQ_W-1:0]   ref_q;
  logic [gbn_pkg::SEQ_W:0]     cur_seq_q;
  logic [gbn_pkg::SEQ_W:0]     last_q;
  logic [gbn_pkg::OFF_W-1:0]   offset_q;
  logic                        empty_q;

  logic                        ack_ok;
  logic [gbn_pkg::SEQ_W:0]     wend_sum;
  logic [gbn_pkg::SEQ_W:0]     wend;
  logic                        win_empty;
  logic                        mul_start;
  logic                        mul_done;
  logic [gbn_pkg::OFF_W-1:0]   mul_product;
  logic                        in_take;
  logic                        out_take;
  logic                        run_end;

  gbn_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gbn_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (ref_q),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_o && !out_stall_i;
  assign run_end     = empty_q || (cur_seq_q == last_q);

  assign ack_ok = (func_q == gbn_pkg::FUNC_ACK) && (ack_q != '0) &&
                  (ack_q >= acked_base_q) && (ack_q <= highest_sent_q);

  assign wend_sum  = {1'b0, acked_base_q} +
                     {{(gbn_pkg::SEQ_W + 1 - gbn_pkg::WIN_W){1'b0}}, cfg.window};
  assign wend      = (wend_sum > {1'b0, cfg.total_segments}) ?
                     {1'b0, cfg.total_segments} : wend_sum;
  assign win_empty = (wend <= {1'b0, ref_q});
  assign mul_start = (state_q == ST_WIN) && !win_empty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_take) state_d = ST_PLAN;
      ST_PLAN: state_d = (func_q == gbn_pkg::FUNC_NONE) ? ST_EMIT : ST_WIN;
      ST_WIN:  state_d = win_empty ? ST_EMIT : ST_MUL;
      ST_MUL:  if (mul_done) state_d = ST_EMIT;
      ST_EMIT: if (out_take && run_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      acked_base_q   <= '0;
      highest_sent_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PLAN) begin
        if (func_q == gbn_pkg::FUNC_START) begin
          acked_base_q   <= '0;
          highest_sent_q <= '0;
        end else if (ack_ok) begin
          acked_base_q <= ack_q;
        end
      end else if (state_q == ST_WIN) begin
        highest_sent_q <= win_empty ? ref_q : wend[gbn_pkg::SEQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= in_data_i.func;
      ack_q  <= in_data_i.ack_number;
    end
    unique case (state_q)
      ST_PLAN: begin
        empty_q <= (func_q == gbn_pkg::FUNC_NONE);
        if (func_q == gbn_pkg::FUNC_START) begin
          ref_q <= '0;
        end else if (ack_ok) begin
          ref_q <= highest_sent_q;
        end else begin
          ref_q <= acked_base_q;
        end
      end
      ST_WIN: begin
        empty_q   <= win_empty;
        cur_seq_q <= {1'b0, ref_q} + 1'b1;
        last_q    <= wend;
      end
      ST_MUL: begin
        if (mul_done) offset_q <= mul_product;
      end
      ST_EMIT: begin
        if (out_take && !run_end) begin
          cur_seq_q <= cur_seq_q + 1'b1;
          offset_q  <= offset_q +
                       {{(gbn_pkg::OFF_W - gbn_pkg::CNT_W){1'b0}}, gbn_pkg::SEGMENT_BYTES};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_o.transfer_done = (acked_base_q >= cfg.total_segments);
    out_data_o.last_of_run   = run_end;
    if (empty_q) begin
      out_data_o.send_valid  = 1'b0;
      out_data_o.seq_number  = '0;
      out_data_o.byte_offset = '0;
      out_data_o.byte_count  = '0;
    end else begin
      out_data_o.send_valid  = 1'b1;
      out_data_o.seq_number  = cur_seq_q[gbn_pkg::SEQ_W-1:0];
      out_data_o.byte_offset = offset_q;
      out_data_o.byte_count  = (cur_seq_q == {1'b0, cfg.total_segments}) ?
                               cfg.last_bytes : gbn_pkg::SEGMENT_BYTES;
    end
  end

endmodule

// ===== design/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the go-back-N sender window core.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_window_core_assert.svh"

module gbn_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gbn_pkg::out_t out_data_o
);

  `GBN_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o)

  `GBN_ASSERT(a_busy_while_out, out_valid_o |-> in_stall_o)

  `GBN_ASSERT(a_status_alone, out_valid_o && !out_data_o.send_valid |-> out_data_o.last_of_run && out_data_o.byte_count == '0)

  `GBN_ASSERT(a_run_advances, out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o && out_data_o.seq_number == $past(out_data_o.seq_number) + 20'd1 && out_data_o.byte_offset == $past(out_data_o.byte_offset) + 31'(gbn_pkg::SEGMENT_BYTES))

  `GBN_ASSERT(a_stall_holds, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker (.*);

// ===== bench/gbn_send_window_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-back-N send window scoreboard
// Tracks the acknowledged base and highest sent sequence number, turns each
// accepted item into the send commands it should produce and matches them,
// in order, against the commands the core delivers.
// ----------------------------------------------------------------------------
package gbn_send_window_sb_pkg;
  import gbn_pkg::*;

  class send_window_scoreboard;
    logic [SEQ_W-1:0] total_segs;
    logic [CNT_W-1:0] last_bytes;
    logic [WIN_W-1:0] window;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] top_sent;
    out_t             expected_sends[$];
    int unsigned      items_seen;
    int unsigned      sends_checked;
    int unsigned      errors;

    function new();
      total_segs    = 1;
      last_bytes    = SEGMENT_BYTES;
      window        = MAX_WINDOW;
      base          = '0;
      top_sent      = '0;
      items_seen    = 0;
      sends_checked = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TOTAL_SEGMENTS: total_segs = data;
        CFG_LAST_BYTES:     last_bytes = data[CNT_W-1:0];
        CFG_WINDOW_SIZE:    window = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned open_end();
      int unsigned w;
      int unsigned e;
      w = window;
      if (w == 0) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      e = base + w;
      if (e > total_segs) e = total_segs;
      return e;
    endfunction

    function void push_sends(int unsigned first, int unsigned last);
      out_t              s;
      int unsigned       q;
      int                n;
      longint unsigned   ofs;
      n = 0;
      for (q = first; q <= last && n < MAX_WINDOW; q++) begin
        s = '0;
        ofs = longint'(q - 1) * longint'(SEGMENT_BYTES);
        s.send_valid    = 1'b1;
        s.seq_number    = q[SEQ_W-1:0];
        s.byte_offset   = ofs[OFF_W-1:0];
        s.byte_count    = SEGMENT_BYTES;
        if (q == total_segs)
          s.byte_count = (last_bytes > SEGMENT_BYTES) ? SEGMENT_BYTES : last_bytes;
        s.transfer_done = (base >= total_segs);
        expected_sends.push_back(s);
        n++;
      end
    endfunction

    function void resend_window();
      int unsigned e;
      e = open_end();
      if (e < base) e = base;
      top_sent = e[SEQ_W-1:0];
      push_sends(base + 1, e);
    endfunction

    function void record_item(in_t it);
      int unsigned n0;
      int unsigned e;
      out_t        s;
      n0 = expected_sends.size();
      case (it.func)
        FUNC_START: begin
          base     = '0;
          top_sent = '0;
          resend_window();
        end
        FUNC_ACK: begin
          if (it.ack_number != 0 && it.ack_number >= base && it.ack_number <= top_sent) begin
            base = it.ack_number;
            e = open_end();
            push_sends(top_sent + 1, e);
            if (e > top_sent) top_sent = e[SEQ_W-1:0];
          end else begin
            resend_window();
          end
        end
        FUNC_TIMEOUT: resend_window();
        default: ;
      endcase
      if (expected_sends.size() == n0) begin
        s = '0;
        s.transfer_done = (base >= total_segs);
        expected_sends.push_back(s);
      end
      s = expected_sends.pop_back();
      s.last_of_run = 1'b1;
      expected_sends.push_back(s);
      items_seen++;
    endfunction

    function void flag(string what, out_t want, out_t got);
      errors++;
      if (errors <= 10)
        $display("%s: expected vld=%0d seq=%0d off=%0d cnt=%0d done=%0d last=%0d, got vld=%0d seq=%0d off=%0d cnt=%0d done=%0d last=%0d",
                 what, want.send_valid, want.seq_number, want.byte_offset, want.byte_count,
                 want.transfer_done, want.last_of_run, got.send_valid, got.seq_number,
                 got.byte_offset, got.byte_count, got.transfer_done, got.last_of_run);
    endfunction

    function void check_send(out_t got);
      out_t want;
      if (expected_sends.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = expected_sends.pop_front();
      sends_checked++;
      if (got.send_valid !== want.send_valid || got.seq_number !== want.seq_number ||
          got.byte_offset !== want.byte_offset || got.byte_count !== want.byte_count ||
          got.transfer_done !== want.transfer_done || got.last_of_run !== want.last_of_run)
        flag("mismatch", want, got);
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-back-N sender window core testbench
// Directed items walk the start, acknowledgement, timeout and unknown codes
// through the window, length and total corner settings; random phases then
// run mostly well-formed transfers, most with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import gbn_pkg::*;
  import gbn_send_window_sb_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int          RANDOM_PER_PHASE = 96;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  send_window_scoreboard sb = new();
  int unsigned           src_idle_pct;
  int unsigned           sink_idle_pct;
  int unsigned           cycles;
  int unsigned           drains;

  go_back_n_sender_window_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[go_back_n_sender_window_core] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_send(out_data);
    out_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  task automatic write_config(logic [CFG_DATA_W-1:0] total, logic [CFG_DATA_W-1:0] last_b,
                              logic [CFG_DATA_W-1:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOTAL_SEGMENTS;
    cfg_data  <= total;
    @(posedge clk);
    sb.write_reg(CFG_TOTAL_SEGMENTS, total);
    cfg_index <= CFG_LAST_BYTES;
    cfg_data  <= last_b;
    @(posedge clk);
    sb.write_reg(CFG_LAST_BYTES, last_b);
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data  <= win;
    @(posedge clk);
    sb.write_reg(CFG_WINDOW_SIZE, win);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(logic [1:0] f, logic [SEQ_W-1:0] a);
    in_t it;
    it.func       = f;
    it.ack_number = a;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.record_item(it);
  endtask

  // hold input until every expected send has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_sends.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drains++;
  endtask

  task automatic random_item();
    logic [1:0]       f;
    logic [SEQ_W-1:0] a;
    int unsigned      r;
    int unsigned      lo;
    r  = $urandom_range(99);
    a  = SEQ_W'($urandom);
    lo = (sb.base == 0) ? 1 : 32'(sb.base);
    if (sb.top_sent == 0 || (sb.base >= sb.total_segs && r < 70) || r < 6) begin
      f = FUNC_START;
    end else if (r < 60) begin
      f = FUNC_ACK;
      a = ($urandom_range(2) == 0) ? sb.top_sent :
          SEQ_W'($urandom_range(32'(sb.top_sent), lo));
    end else if (r < 78) begin
      f = FUNC_TIMEOUT;
    end else if (r < 92) begin
      f = FUNC_ACK;
      case ($urandom_range(3))
        0: a = '0;
        1: a = SEQ_W'(sb.top_sent + 1 + $urandom_range(5));
        2: a = (sb.base == 0) ? '0 : sb.base - 1'b1;
        default: ;
      endcase
    end else begin
      f = FUNC_NONE;
    end
    push_item(f, a);
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned sink_pct,
                           logic [CFG_DATA_W-1:0] total, logic [CFG_DATA_W-1:0] last_b,
                           logic [CFG_DATA_W-1:0] win);
    drain();
    write_config(total, last_b, win);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (RANDOM_PER_PHASE) begin
      if ($urandom_range(99) < 3) drain();
      random_item();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    src_idle_pct  = 17;
    sink_idle_pct = 55;
    drains        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_config(1, 1494, 64);
    push_item(FUNC_NONE, 20'hFFFFF);
    push_item(FUNC_ACK, '0);
    push_item(FUNC_TIMEOUT, 20'hFFFFF);
    push_item(FUNC_ACK, 20'd1);
    push_item(FUNC_TIMEOUT, '0);
    push_item(FUNC_START, 20'hFFFFF);

    drain();
    write_config(200, 0, 0);
    push_item(FUNC_START, '0);
    push_item(FUNC_ACK, 20'd1);
    push_item(FUNC_ACK, 20'd5);
    push_item(FUNC_ACK, '0);
    push_item(FUNC_ACK, 20'd1);

    drain();
    write_config(130, 2047, 127);
    push_item(FUNC_START, '0);
    push_item(FUNC_ACK, 20'd64);
    push_item(FUNC_ACK, 20'd100);
    push_item(FUNC_ACK, 20'd99);
    push_item(FUNC_ACK, 20'd130);
    push_item(FUNC_TIMEOUT, '0);

    // shrink the total below the acknowledged base
    drain();
    write_config(50, 7, 64);
    push_item(FUNC_TIMEOUT, '0);
    push_item(FUNC_ACK, 20'd130);
    push_item(FUNC_START, '0);
    push_item(FUNC_ACK, 20'd20);

    run_phase(17, 55, 999999, 1, 1);
    run_phase(55, 17, CFG_DATA_W'($urandom_range(300, 1)),
              CFG_DATA_W'($urandom_range(2047, 0)), CFG_DATA_W'($urandom_range(127, 0)));
    run_phase(0, 0, 20'hFFFFF, 1494, 64);

    drain();
    repeat (100) @(posedge clk);
    if (sb.expected_sends.size() != 0) begin
      $display("%0d expected results never arrived", sb.expected_sends.size());
      sb.errors += sb.expected_sends.size();
    end
    $display("Sent %0d items and checked %0d results in %0d cycles, %0d full pauses.",
             sb.items_seen, sb.sends_checked, cycles, drains);
    $display("Windows 0 to 127, totals 1 to 1048575, last lengths 0 to 2047; %0d errors.",
             sb.errors);
    if (sb.errors == 0)
      $display("[go_back_n_sender_window_core] OK");
    else
      $display("[go_back_n_sender_window_core] ERROR");
    $finish;
  end

endmodule
